@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/lhnu_pkg.sv @@
// Shared types and constants of the Link header next-URL parser.
`default_nettype none

package lhnu_pkg;

  typedef enum logic [11:0] {
    PH_SEEK       = 12'b0000_0000_0001,
    PH_MALFORMED  = 12'b0000_0000_0010,
    PH_URL        = 12'b0000_0000_0100,
    PH_PARAMS     = 12'b0000_0000_1000,
    PH_NAME_WS    = 12'b0000_0001_0000,
    PH_NAME       = 12'b0000_0010_0000,
    PH_NAME_AFTER = 12'b0000_0100_0000,
    PH_VAL_WS     = 12'b0000_1000_0000,
    PH_VAL_Q      = 12'b0001_0000_0000,
    PH_VAL_BARE   = 12'b0010_0000_0000,
    PH_DONE       = 12'b0100_0000_0000,
    PH_ENDED      = 12'b1000_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    V_UNDECIDED = 2'd0,
    V_FOUND     = 2'd1,
    V_ABSENT    = 2'd2
  } verdict_t;

  localparam logic OP_PARSE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [2:0] NAME_MATCH = 3'd3;
  localparam logic [2:0] NAME_MISS  = 3'd4;
  localparam logic [2:0] TOKEN_MATCH = 3'd4;
  localparam logic [2:0] TOKEN_MISS  = 3'd5;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;

  localparam logic [8:0] URL_LIMIT_RST = 9'd255;

  typedef struct packed {
    phase_t     phase;
    logic       url_overflow;
    logic       quote_single;
    logic [2:0] name_progress;
    logic [2:0] token_progress;
    logic       value_has_next;
    logic       link_is_next;
    verdict_t   verdict;
  } parse_st_t;

  localparam parse_st_t PARSE_CLEAR = '{
    phase:          PH_SEEK,
    url_overflow:   1'b0,
    quote_single:   1'b0,
    name_progress:  3'd0,
    token_progress: 3'd0,
    value_has_next: 1'b0,
    link_is_next:   1'b0,
    verdict:        V_UNDECIDED
  };

endpackage

`default_nettype wire

@@ design/lhnu_url_mem.sv @@
// URL byte store: one write port, one registered read port.
`default_nettype none

module lhnu_url_mem #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/lhnu_parser.sv @@
// Per-character parse state machine: one header character per cycle in which go is high.
`default_nettype none

module lhnu_parser #(
  parameter int unsigned URL_DEPTH = 256,
  localparam int unsigned CNT_W = $clog2(URL_DEPTH + 1),
  localparam int unsigned AW    = $clog2(URL_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [7:0]       char_byte,
  input  wire logic             last,
  input  wire logic [8:0]       url_limit,
  output logic                  mem_we,
  output logic      [AW-1:0]    mem_waddr,
  output logic      [7:0]       mem_wdata,
  output lhnu_pkg::verdict_t    verdict_nxt,
  output logic      [CNT_W-1:0] count_nxt
);

  localparam int unsigned CMP_W = (CNT_W > 9) ? CNT_W : 9;

  lhnu_pkg::parse_st_t st_r, st_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {lhnu_pkg::CH_SP, lhnu_pkg::CH_TAB, lhnu_pkg::CH_CR, lhnu_pkg::CH_LF};
  endfunction

  function automatic logic [7:0] rel_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h72;
      3'd1:    r = 8'h65;
      3'd2:    r = 8'h6C;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] next_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h6E;
      3'd1:    r = 8'h65;
      3'd2:    r = 8'h78;
      3'd3:    r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic lhnu_pkg::parse_st_t token_end(input lhnu_pkg::parse_st_t s);
    lhnu_pkg::parse_st_t o;
    o = s;
    if (s.token_progress == lhnu_pkg::TOKEN_MATCH) begin
      o.value_has_next = 1'b1;
    end
    o.token_progress = 3'd0;
    return o;
  endfunction

  function automatic lhnu_pkg::parse_st_t token_char(input lhnu_pkg::parse_st_t s,
                                                     input logic [7:0] c);
    lhnu_pkg::parse_st_t o;
    o = s;
    if (s.token_progress < lhnu_pkg::TOKEN_MATCH &&
        to_lower(c) == next_char(s.token_progress)) begin
      o.token_progress = s.token_progress + 3'd1;
    end else begin
      o.token_progress = lhnu_pkg::TOKEN_MISS;
    end
    return o;
  endfunction

  function automatic lhnu_pkg::parse_st_t finish_value(input lhnu_pkg::parse_st_t s);
    lhnu_pkg::parse_st_t o;
    o = token_end(s);
    if (o.name_progress == lhnu_pkg::NAME_MATCH && o.value_has_next) begin
      o.link_is_next = 1'b1;
    end
    o.value_has_next = 1'b0;
    return o;
  endfunction

  function automatic lhnu_pkg::parse_st_t start_value(input lhnu_pkg::parse_st_t s);
    lhnu_pkg::parse_st_t o;
    o = s;
    o.token_progress = 3'd0;
    o.value_has_next = 1'b0;
    return o;
  endfunction

  function automatic lhnu_pkg::parse_st_t decide(input lhnu_pkg::parse_st_t s);
    lhnu_pkg::parse_st_t o;
    o = s;
    o.verdict = (s.link_is_next && !s.url_overflow) ? lhnu_pkg::V_FOUND : lhnu_pkg::V_ABSENT;
    o.phase   = lhnu_pkg::PH_DONE;
    return o;
  endfunction

  // End of string: settle whatever link-value is open.
  function automatic lhnu_pkg::parse_st_t end_event(input lhnu_pkg::parse_st_t s);
    lhnu_pkg::parse_st_t o;
    o = s;
    case (s.phase)
      lhnu_pkg::PH_SEEK, lhnu_pkg::PH_MALFORMED, lhnu_pkg::PH_URL: begin
        o.verdict = lhnu_pkg::V_ABSENT;
        o.phase   = lhnu_pkg::PH_DONE;
      end
      lhnu_pkg::PH_VAL_WS: begin
        o = decide(finish_value(start_value(s)));
      end
      lhnu_pkg::PH_VAL_Q, lhnu_pkg::PH_VAL_BARE: begin
        o = decide(finish_value(s));
      end
      lhnu_pkg::PH_PARAMS, lhnu_pkg::PH_NAME_WS, lhnu_pkg::PH_NAME,
      lhnu_pkg::PH_NAME_AFTER: begin
        o = decide(s);
      end
      default: begin
        o = s;
      end
    endcase
    return o;
  endfunction

  always_comb begin
    lhnu_pkg::parse_st_t s;
    logic [CNT_W-1:0]    cnt;
    logic                again;
    s         = st_r;
    cnt       = cnt_r;
    again     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cnt_r[AW-1:0];
    mem_wdata = char_byte;
    if (go) begin
      if (s.phase == lhnu_pkg::PH_ENDED) begin
        s   = lhnu_pkg::PARSE_CLEAR;
        cnt = '0;
      end
      if (s.phase != lhnu_pkg::PH_DONE) begin
        if (char_byte == lhnu_pkg::CH_NUL) begin
          s = end_event(s);
        end else begin
          // A character can fall through at most four phases (name to params).
          again = 1'b1;
          for (int i = 0; i < 4; i++) begin
            if (again) begin
              again = 1'b0;
              case (s.phase)
                lhnu_pkg::PH_SEEK: begin
                  if (!is_ws(char_byte) && char_byte != lhnu_pkg::CH_COMMA) begin
                    if (char_byte == lhnu_pkg::CH_LT) begin
                      cnt            = '0;
                      s.url_overflow = 1'b0;
                      s.link_is_next = 1'b0;
                      s.phase        = lhnu_pkg::PH_URL;
                    end else begin
                      s.phase = lhnu_pkg::PH_MALFORMED;
                    end
                  end
                end
                lhnu_pkg::PH_MALFORMED: begin
                  if (char_byte == lhnu_pkg::CH_COMMA) begin
                    s.phase = lhnu_pkg::PH_SEEK;
                  end
                end
                lhnu_pkg::PH_URL: begin
                  if (char_byte == lhnu_pkg::CH_GT) begin
                    s.phase = lhnu_pkg::PH_PARAMS;
                  end else if ((CMP_W'(cnt) >= CMP_W'(url_limit)) ||
                               (cnt == CNT_W'(URL_DEPTH))) begin
                    s.url_overflow = 1'b1;
                  end else begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt[AW-1:0];
                    cnt       = cnt + CNT_W'(1);
                  end
                end
                lhnu_pkg::PH_PARAMS: begin
                  if (char_byte == lhnu_pkg::CH_COMMA) begin
                    if (s.link_is_next) begin
                      s = decide(s);
                    end else begin
                      s.phase = lhnu_pkg::PH_SEEK;
                    end
                  end else if (char_byte == lhnu_pkg::CH_SEMI) begin
                    s.phase = lhnu_pkg::PH_NAME_WS;
                  end
                end
                lhnu_pkg::PH_NAME_WS: begin
                  if (!is_ws(char_byte)) begin
                    s.name_progress = 3'd0;
                    s.phase         = lhnu_pkg::PH_NAME;
                    again           = 1'b1;
                  end
                end
                lhnu_pkg::PH_NAME: begin
                  if (char_byte inside {lhnu_pkg::CH_EQ, lhnu_pkg::CH_SEMI, lhnu_pkg::CH_COMMA,
                                        lhnu_pkg::CH_SP, lhnu_pkg::CH_TAB}) begin
                    s.phase = lhnu_pkg::PH_NAME_AFTER;
                    again   = 1'b1;
                  end else if (s.name_progress < lhnu_pkg::NAME_MATCH &&
                               to_lower(char_byte) == rel_char(s.name_progress)) begin
                    s.name_progress = s.name_progress + 3'd1;
                  end else begin
                    s.name_progress = lhnu_pkg::NAME_MISS;
                  end
                end
                lhnu_pkg::PH_NAME_AFTER: begin
                  if (!is_ws(char_byte)) begin
                    if (char_byte == lhnu_pkg::CH_EQ) begin
                      s.phase = lhnu_pkg::PH_VAL_WS;
                    end else begin
                      s.phase = lhnu_pkg::PH_PARAMS;
                      again   = 1'b1;
                    end
                  end
                end
                lhnu_pkg::PH_VAL_WS: begin
                  if (!is_ws(char_byte)) begin
                    s = start_value(s);
                    if (char_byte == lhnu_pkg::CH_DQUOTE ||
                        char_byte == lhnu_pkg::CH_SQUOTE) begin
                      s.quote_single = (char_byte == lhnu_pkg::CH_SQUOTE);
                      s.phase        = lhnu_pkg::PH_VAL_Q;
                    end else begin
                      s.phase = lhnu_pkg::PH_VAL_BARE;
                      again   = 1'b1;
                    end
                  end
                end
                lhnu_pkg::PH_VAL_Q: begin
                  if (char_byte ==
                      (s.quote_single ? lhnu_pkg::CH_SQUOTE : lhnu_pkg::CH_DQUOTE)) begin
                    s       = finish_value(s);
                    s.phase = lhnu_pkg::PH_PARAMS;
                  end else if (char_byte == lhnu_pkg::CH_SP ||
                               char_byte == lhnu_pkg::CH_TAB) begin
                    s = token_end(s);
                  end else begin
                    s = token_char(s, char_byte);
                  end
                end
                lhnu_pkg::PH_VAL_BARE: begin
                  if (char_byte inside {lhnu_pkg::CH_SEMI, lhnu_pkg::CH_COMMA,
                                        lhnu_pkg::CH_SP, lhnu_pkg::CH_TAB}) begin
                    s       = finish_value(s);
                    s.phase = lhnu_pkg::PH_PARAMS;
                    again   = 1'b1;
                  end else begin
                    s = token_char(s, char_byte);
                  end
                end
                default: begin
                  s = s;
                end
              endcase
            end
          end
        end
      end
      if (last) begin
        if (s.phase != lhnu_pkg::PH_DONE) begin
          s = end_event(s);
        end
        s.phase = lhnu_pkg::PH_ENDED;
      end
    end
    st_nxt  = s;
    cnt_nxt = cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= lhnu_pkg::PARSE_CLEAR;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign verdict_nxt = st_nxt.verdict;
  assign count_nxt   = cnt_nxt;

endmodule

`default_nettype wire

@@ design/link_header_next_url_parser_core.sv @@
// Scans an HTTP Link header one character per item and keeps the URL of the first link-value
// whose rel parameter holds the token "next"; read items fetch the stored URL bytes. Every
// item, parse or read, has its result captured in the output register and shown on the next
// clock; a new item can be taken every clock while the result is not stalled. The parse
// state machine settles each character before the next is taken, and the URL store has
// one write port and one registered read port, so a read sees every earlier write.
// No clearing pass is needed after reset.
`default_nettype none

module link_header_next_url_parser_core #(
  parameter int unsigned URL_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_operation,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_last,
  input  wire logic [7:0] in_read_index,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [1:0] out_status,
  output logic      [8:0] out_url_length,
  output logic      [7:0] out_read_byte,
  input  wire logic       cfg_wr_en,
  input  wire logic [8:0] cfg_wr_data
);

  localparam int unsigned CNT_W = $clog2(URL_DEPTH + 1);
  localparam int unsigned AW    = $clog2(URL_DEPTH);
  localparam int unsigned CMP_W = (CNT_W > 9) ? CNT_W : 9;

  logic [8:0]         url_limit_r;
  logic               in_acc;
  logic               parse_go;
  logic               read_go;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [7:0]         mem_wdata;
  logic [7:0]         mem_rdata_r;
  lhnu_pkg::verdict_t verdict_nxt;
  logic [CNT_W-1:0]   count_nxt;
  logic [CMP_W-1:0]   idx_ext;
  logic [CMP_W-1:0]   len_ext;
  logic               rd_ok;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         status_r;
  logic [8:0]         url_length_r;
  logic               rd_ok_r;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign parse_go = in_acc && (in_operation == lhnu_pkg::OP_PARSE);
  assign read_go  = in_acc && (in_operation == lhnu_pkg::OP_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      url_limit_r <= lhnu_pkg::URL_LIMIT_RST;
    end else if (cfg_wr_en) begin
      url_limit_r <= cfg_wr_data;
    end
  end

  lhnu_parser #(
    .URL_DEPTH (URL_DEPTH)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (parse_go),
    .char_byte   (in_char_byte),
    .last        (in_last),
    .url_limit   (url_limit_r),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .verdict_nxt (verdict_nxt),
    .count_nxt   (count_nxt)
  );

  assign idx_ext = CMP_W'(in_read_index);

  lhnu_url_mem #(
    .DEPTH (URL_DEPTH)
  ) u_url_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (read_go),
    .raddr   (idx_ext[AW-1:0]),
    .rdata_r (mem_rdata_r)
  );

  // Read items leave the parse state alone, so the next-state values are the current ones.
  assign rd_ok = read_go && (verdict_nxt == lhnu_pkg::V_FOUND) &&
                 (idx_ext < CMP_W'(count_nxt)) && (idx_ext < CMP_W'(URL_DEPTH));
  assign len_ext = (verdict_nxt == lhnu_pkg::V_FOUND) ? CMP_W'(count_nxt) : '0;

  always_comb begin
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r     <= verdict_nxt;
      url_length_r <= len_ext[8:0];
      rd_ok_r      <= rd_ok;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_url_length = url_length_r;
  assign out_read_byte  = rd_ok_r ? mem_rdata_r : 8'd0;

endmodule

`default_nettype wire

@@ design/lhnu_checker.sv @@
// Port-level checks on the parser core, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module lhnu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_status,
  input wire logic [8:0] out_url_length,
  input wire logic [7:0] out_read_byte
);

  `ASSERT_CLK_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid, "result valid after reset")

  `ASSERT_CLK_ALWAYS(a_stall_only_full, in_stall |-> (out_valid && out_stall), "input stalled without a held result")

  `ASSERT_CLK(a_no_data_unless_found, (out_valid && out_status != lhnu_pkg::V_FOUND) |-> (out_url_length == 9'd0 && out_read_byte == 8'd0), "URL data shown without a found verdict")

  `ASSERT_CLK(a_held_result, (out_valid && out_stall) |=> (out_valid && $stable(out_status) && $stable(out_url_length) && $stable(out_read_byte)), "stalled result changed")

endmodule

bind link_header_next_url_parser_core lhnu_checker u_lhnu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_url_length (out_url_length),
  .out_read_byte  (out_read_byte)
);

`default_nettype wire
